### hdl/fte_pkg.sv
// Shared types and codes for the exact-match flow table.
package fte_pkg;

  // Width of the slot number carried on the ports.
  localparam int SLOT_W = 4;

  // Stored action codes of a table entry.
  localparam logic [1:0] ACT_FLOOD = 2'd0;
  localparam logic [1:0] ACT_PORT  = 2'd1;
  localparam logic [1:0] ACT_CTRL  = 2'd2;
  localparam logic [1:0] ACT_DROP  = 2'd3;

  // Decision codes of a result.
  localparam logic [2:0] DEC_MISS  = 3'd0;
  localparam logic [2:0] DEC_FLOOD = 3'd1;
  localparam logic [2:0] DEC_PORT  = 3'd2;
  localparam logic [2:0] DEC_CTRL  = 3'd3;
  localparam logic [2:0] DEC_DROP  = 3'd4;
  localparam logic [2:0] DEC_WRITE = 3'd5;

  // Function codes of an input item.
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_WRITE  = 1'b1;

  // Input item: a packet header for lookup, or an entry to write.
  typedef struct packed {
    logic              func;
    logic [SLOT_W-1:0] entry_index;
    logic [15:0]       eth_type;
    logic [47:0]       mac_src;
    logic [47:0]       mac_dst;
    logic [7:0]        in_port;
    logic [7:0]        l4_proto;
    logic [7:0]        tos_byte;
    logic [31:0]       src_ipv4;
    logic [31:0]       dst_ipv4;
    logic [1:0]        entry_action;
    logic [7:0]        entry_out_port;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [2:0]        decision;
    logic [7:0]        out_port;
    logic [SLOT_W-1:0] hit_index;
  } out_item_t;

  // One stored table entry.
  typedef struct packed {
    logic [15:0] eth_type;
    logic [47:0] mac_src;
    logic [47:0] mac_dst;
    logic [7:0]  in_port;
    logic [7:0]  l4_proto;
    logic [7:0]  tos_byte;
    logic [31:0] src_ipv4;
    logic [31:0] dst_ipv4;
    logic [1:0]  action;
    logic [7:0]  out_port;
  } entry_t;

  // Control states of the lookup engine.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

endpackage

### hdl/fte_table.sv
// Flow table storage: entry memory with one write and one registered read port.
module fte_table #(
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  fte_pkg::entry_t wr_entry,
  input  logic [AW-1:0]   rd_addr,
  output fte_pkg::entry_t rd_entry
);
  import fte_pkg::*;

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  entry_t           rd_data_r;
  logic             rd_vld_r;

  // Entry memory: write on request, registered read every cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Per-entry valid bits model the cleared table after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // A never-written entry reads as all zero, which marks the end of the table.
  assign rd_entry = rd_vld_r ? rd_data_r : '0;

endmodule

### hdl/flow_table_exact_match_top.sv
// Exact-match flow table: entry writes and sequential lookups over a table memory.
// A write is handled in the idle state; its result is registered at once if the output is free.
// A lookup reads one entry per cycle from the table memory, in order from slot 0,
// until a match, an end-of-table entry or the last slot; no next item is taken
// before it ends. Results wait in a hold register while the output register is full.
// Synchronous active-low reset clears the control state and marks every slot empty.
module flow_table_exact_match_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fte_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fte_pkg::out_item_t  out_data
);
  import fte_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  state_t           state_r, state_nxt;
  in_item_t         key_r, key_nxt;
  logic [IDX_W-1:0] issue_idx_r, issue_idx_nxt;
  logic             issue_on_r, issue_on_nxt;
  logic [IDX_W-1:0] rd_idx_r;
  logic             rd_ok_r, rd_ok_nxt;
  out_item_t        res_r, res_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             in_fire;
  logic             out_free;
  logic             wr_en;
  entry_t           wr_entry;
  entry_t           rd_entry;
  logic             ent_stop;
  logic             ent_match;
  logic             scan_hit;
  logic             scan_miss;
  logic             scan_done;
  out_item_t        hit_res;
  out_item_t        scan_res;
  out_item_t        wr_res;

  // Handshake.
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Table write on the transfer of a write item; slots beyond the table are ignored.
  assign wr_en = in_fire && (in_data.func == FUNC_WRITE) &&
                 (32'(in_data.entry_index) < 32'(TABLE_DEPTH));

  always_comb begin
    wr_entry.eth_type = in_data.eth_type;
    wr_entry.mac_src  = in_data.mac_src;
    wr_entry.mac_dst  = in_data.mac_dst;
    wr_entry.in_port  = in_data.in_port;
    wr_entry.l4_proto = in_data.l4_proto;
    wr_entry.tos_byte = in_data.tos_byte;
    wr_entry.src_ipv4 = in_data.src_ipv4;
    wr_entry.dst_ipv4 = in_data.dst_ipv4;
    wr_entry.action   = in_data.entry_action;
    wr_entry.out_port = in_data.entry_out_port;
  end

  fte_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (IDX_W'(in_data.entry_index)),
    .wr_entry (wr_entry),
    .rd_addr  (issue_idx_r),
    .rd_entry (rd_entry)
  );

  // Compare the entry returned by the memory against the held packet header.
  always_comb begin
    ent_stop  = (rd_entry.eth_type == '0) || (rd_entry.src_ipv4[31:24] == '0);
    ent_match = (rd_entry.eth_type == key_r.eth_type) &&
                (rd_entry.mac_src  == key_r.mac_src)  &&
                (rd_entry.mac_dst  == key_r.mac_dst)  &&
                (rd_entry.in_port  == key_r.in_port)  &&
                (rd_entry.l4_proto == key_r.l4_proto) &&
                (rd_entry.tos_byte == key_r.tos_byte) &&
                (rd_entry.src_ipv4 == key_r.src_ipv4) &&
                (rd_entry.dst_ipv4 == key_r.dst_ipv4);
    scan_hit  = (state_r == ST_SCAN) && rd_ok_r && !ent_stop && ent_match;
    scan_miss = (state_r == ST_SCAN) && rd_ok_r &&
                (ent_stop || (!ent_match && (rd_idx_r == LAST_IDX)));
    scan_done = scan_hit || scan_miss;
  end

  // Build the candidate results.
  always_comb begin
    case (rd_entry.action)
      ACT_FLOOD: hit_res.decision = DEC_FLOOD;
      ACT_PORT:  hit_res.decision = DEC_PORT;
      ACT_CTRL:  hit_res.decision = DEC_CTRL;
      default:   hit_res.decision = DEC_DROP;
    endcase
    hit_res.out_port  = (rd_entry.action == ACT_PORT) ? rd_entry.out_port : '0;
    hit_res.hit_index = SLOT_W'(rd_idx_r);

    if (scan_hit) begin
      scan_res = hit_res;
    end else begin
      scan_res          = '0;
      scan_res.decision = DEC_MISS;
    end

    wr_res.decision  = DEC_WRITE;
    wr_res.out_port  = '0;
    wr_res.hit_index = in_data.entry_index;
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.func == FUNC_WRITE) begin
            state_nxt = out_free ? ST_IDLE : ST_HOLD;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and output-register control.
  always_comb begin
    key_nxt       = key_r;
    issue_idx_nxt = issue_idx_r;
    issue_on_nxt  = issue_on_r;
    rd_ok_nxt     = (state_r == ST_SCAN) && issue_on_r && !scan_done;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.func == FUNC_WRITE) begin
            if (out_free) begin
              out_nxt       = wr_res;
              out_valid_nxt = 1'b1;
            end else begin
              res_nxt = wr_res;
            end
          end else begin
            key_nxt       = in_data;
            issue_idx_nxt = '0;
            issue_on_nxt  = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        // Issue the next slot read until the end of the table or the end of the scan.
        if (issue_on_r) begin
          if (issue_idx_r == LAST_IDX) begin
            issue_on_nxt = 1'b0;
          end else begin
            issue_idx_nxt = issue_idx_r + IDX_W'(1);
          end
        end
        if (scan_done) begin
          issue_on_nxt = 1'b0;
          if (out_free) begin
            out_nxt       = scan_res;
            out_valid_nxt = 1'b1;
          end else begin
            res_nxt = scan_res;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        issue_on_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_on_r  <= 1'b0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_on_r  <= issue_on_nxt;
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    issue_idx_r <= issue_idx_nxt;
    rd_idx_r    <= issue_idx_r;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

endmodule

### test/testbench.sv
// Self-checking testbench for the exact-match flow table: random stimulus, scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fte_pkg::*;

  localparam int SLOTS = 16;
  localparam int ITEM_TARGET = 2000;
  localparam int EPISODE_LOOKUPS = 40;
  localparam int IDLE_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 4 * (SLOTS + 2);
  // Header fields of an entry sit above the action and the output port.
  localparam int HDR_LO = 10;
  localparam int HDR_HI = $bits(entry_t) - 1;

  // A pending packet or entry write, optionally held back until all results are in.
  typedef struct packed {
    logic     drain_first;
    in_item_t item;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  stim_t     queued_packets [$];
  out_item_t pending_decisions [$];
  entry_t    flow_table [SLOTS];
  entry_t    planned_table [SLOTS];
  int        total_items = 0;
  int        sent_count = 0;
  int        got_count = 0;
  int        results_seen = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        idle_cycles = 0;
  bit        failed = 1'b0;

  flow_table_exact_match_top #(.TABLE_DEPTH(SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Header, action and port of an item, laid out as a stored entry.
  function automatic entry_t entry_of(in_item_t pkt);
    entry_t e;
    e.eth_type = pkt.eth_type;
    e.mac_src  = pkt.mac_src;
    e.mac_dst  = pkt.mac_dst;
    e.in_port  = pkt.in_port;
    e.l4_proto = pkt.l4_proto;
    e.tos_byte = pkt.tos_byte;
    e.src_ipv4 = pkt.src_ipv4;
    e.dst_ipv4 = pkt.dst_ipv4;
    e.action   = pkt.entry_action;
    e.out_port = pkt.entry_out_port;
    return e;
  endfunction

  // Expected decision for one item; writes update the table copy.
  function automatic out_item_t resolve_flow(in_item_t pkt);
    out_item_t res;
    entry_t    probe;
    entry_t    slot;
    bit        stop;
    res = '0;
    probe = entry_of(pkt);
    if (pkt.func == FUNC_WRITE) begin
      flow_table[pkt.entry_index] = probe;
      res.decision = DEC_WRITE;
      res.hit_index = pkt.entry_index;
    end else begin
      stop = 1'b0;
      for (int k = 0; k < SLOTS && !stop; k++) begin
        slot = flow_table[k];
        if (slot.eth_type == 16'h0 || slot.src_ipv4[31:24] == 8'h0) begin
          stop = 1'b1;
        end else if (slot[HDR_HI:HDR_LO] == probe[HDR_HI:HDR_LO]) begin
          stop = 1'b1;
          case (slot.action)
            ACT_FLOOD: res.decision = DEC_FLOOD;
            ACT_PORT:  res.decision = DEC_PORT;
            ACT_CTRL:  res.decision = DEC_CTRL;
            default:   res.decision = DEC_DROP;
          endcase
          res.out_port = (slot.action == ACT_PORT) ? slot.out_port : 8'h0;
          res.hit_index = SLOT_W'(k);
        end
      end
    end
    return res;
  endfunction

  // Fully random entry; it may well mark the end of the table.
  function automatic entry_t raw_entry();
    entry_t e;
    for (int b = 0; b < $bits(entry_t); b++) e[b] = 1'($urandom);
    return e;
  endfunction

  // Random entry that a lookup scan can pass over.
  function automatic entry_t random_entry();
    entry_t e;
    e = raw_entry();
    e.eth_type = 16'($urandom_range(1, 65535));
    e.src_ipv4[31:24] = 8'($urandom_range(1, 255));
    return e;
  endfunction

  // Same header with a single bit flipped.
  function automatic entry_t nudge(entry_t e);
    entry_t n;
    n = e;
    n[$urandom_range(HDR_LO, HDR_HI)] ^= 1'b1;
    return n;
  endfunction

  function automatic void add_item(in_item_t item, bit drain);
    stim_t s;
    s.drain_first = drain;
    s.item = item;
    queued_packets.push_back(s);
  endfunction

  function automatic void add_write(logic [SLOT_W-1:0] idx, entry_t e, bit drain);
    in_item_t item;
    item = '0;
    item.func           = FUNC_WRITE;
    item.entry_index    = idx;
    item.eth_type       = e.eth_type;
    item.mac_src        = e.mac_src;
    item.mac_dst        = e.mac_dst;
    item.in_port        = e.in_port;
    item.l4_proto       = e.l4_proto;
    item.tos_byte       = e.tos_byte;
    item.src_ipv4       = e.src_ipv4;
    item.dst_ipv4       = e.dst_ipv4;
    item.entry_action   = e.action;
    item.entry_out_port = e.out_port;
    planned_table[idx] = e;
    add_item(item, drain);
  endfunction

  // Lookup with the header of e; the write-only fields carry random noise.
  function automatic void add_lookup(entry_t e, bit drain);
    in_item_t item;
    item = '0;
    item.func           = FUNC_LOOKUP;
    item.entry_index    = SLOT_W'($urandom);
    item.eth_type       = e.eth_type;
    item.mac_src        = e.mac_src;
    item.mac_dst        = e.mac_dst;
    item.in_port        = e.in_port;
    item.l4_proto       = e.l4_proto;
    item.tos_byte       = e.tos_byte;
    item.src_ipv4       = e.src_ipv4;
    item.dst_ipv4       = e.dst_ipv4;
    item.entry_action   = 2'($urandom);
    item.entry_out_port = 8'($urandom);
    add_item(item, drain);
  endfunction

  // Directed cases: empty table, each action, first match, scan terminators.
  function automatic void queue_directed();
    entry_t e;
    for (int k = 0; k < SLOTS; k++) planned_table[k] = '0;
    add_lookup('0, 1'b0);
    e = '1;
    e.action = ACT_FLOOD;
    e.out_port = 8'hA5;
    add_write(SLOT_W'(0), e, 1'b0);
    add_lookup(e, 1'b0);
    e = random_entry();
    e.action = ACT_PORT;
    e.out_port = 8'hFF;
    add_write(SLOT_W'(1), e, 1'b0);
    e = random_entry();
    e.action = ACT_CTRL;
    add_write(SLOT_W'(2), e, 1'b0);
    // Smallest header that still keeps the scan going.
    e = '0;
    e.eth_type = 16'h0001;
    e.src_ipv4 = 32'h0100_0000;
    e.action = ACT_DROP;
    add_write(SLOT_W'(3), e, 1'b0);
    for (int k = 1; k <= 3; k++) add_lookup(planned_table[k], 1'b0);
    // A later entry with the same header must lose to the earlier one.
    e = planned_table[1];
    e.action = ACT_DROP;
    add_write(SLOT_W'(4), e, 1'b0);
    add_lookup(e, 1'b0);
    add_lookup(nudge(planned_table[2]), 1'b0);
    // A zero EtherType ends the scan, hiding the entry behind it.
    e = random_entry();
    e.eth_type = 16'h0;
    add_write(SLOT_W'(5), e, 1'b0);
    add_write(SLOT_W'(6), random_entry(), 1'b0);
    add_lookup(planned_table[6], 1'b0);
    add_lookup(planned_table[5], 1'b0);
    // A zero top byte of the source address ends the scan too.
    e = random_entry();
    e.src_ipv4[31:24] = 8'h0;
    add_write(SLOT_W'(5), e, 1'b0);
    add_lookup(planned_table[5], 1'b0);
    add_lookup(planned_table[6], 1'b0);
    add_lookup(planned_table[0], 1'b0);
  endfunction

  // Episodes: build a chain of live entries, then look up mostly known headers.
  function automatic void queue_random();
    entry_t e;
    int     chain;
    int     r;
    bit     first_episode;
    first_episode = 1'b1;
    while (queued_packets.size() < ITEM_TARGET) begin
      if (first_episode || $urandom_range(0, 3) == 0) chain = SLOTS;
      else chain = $urandom_range(1, SLOTS - 1);
      first_episode = 1'b0;
      for (int k = 0; k < chain; k++) begin
        if (k > 0 && $urandom_range(0, 4) == 0) begin
          e = planned_table[$urandom_range(0, k - 1)];
          e.action = 2'($urandom);
          e.out_port = 8'($urandom);
        end else begin
          e = random_entry();
        end
        add_write(SLOT_W'(k), e, k == 0);
      end
      if (chain < SLOTS) begin
        e = random_entry();
        if ($urandom_range(0, 1) == 0) e.eth_type = 16'h0;
        else e.src_ipv4[31:24] = 8'h0;
        add_write(SLOT_W'(chain), e, 1'b0);
      end
      for (int n = 0; n < EPISODE_LOOKUPS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 55) add_lookup(planned_table[$urandom_range(0, SLOTS - 1)], 1'b0);
        else if (r < 75) add_lookup(nudge(planned_table[$urandom_range(0, SLOTS - 1)]), 1'b0);
        else if (r < 85) add_lookup(raw_entry(), 1'b0);
        else if (r < 95) add_write(SLOT_W'($urandom), random_entry(), 1'b0);
        else add_write(SLOT_W'($urandom), raw_entry(), 1'b0);
      end
    end
  endfunction

  // Sender: presents queued items, with random gaps between transfers.
  always @(posedge clk) begin
    stim_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
      for (int k = 0; k < SLOTS; k++) flow_table[k] = '0;
    end else begin
      if (in_valid && in_ready) begin
        pending_decisions.push_back(resolve_flow(in_data));
        sent_count++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (queued_packets.size() > 0 &&
                     !(queued_packets[0].drain_first && sent_count != results_seen)) begin
          nxt = queued_packets.pop_front();
          in_data <= nxt.item;
          in_valid <= 1'b1;
          gap_left = ((sent_count % 256) < 48) ? 0 : $urandom_range(0, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transfer against the oldest expected decision.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        got_count++;
        if (pending_decisions.size() == 0) begin
          $display("%0t: unexpected result, got decision %0d port %0d index %0d",
                   $time, out_data.decision, out_data.out_port, out_data.hit_index);
          failed = 1'b1;
        end else begin
          want = pending_decisions.pop_front();
          if (out_data.decision !== want.decision) begin
            $display("%0t: decision mismatch, expected %0d, got %0d",
                     $time, want.decision, out_data.decision);
            failed = 1'b1;
          end
          if (out_data.out_port !== want.out_port) begin
            $display("%0t: out_port mismatch, expected %0d, got %0d",
                     $time, want.out_port, out_data.out_port);
            failed = 1'b1;
          end
          if (out_data.hit_index !== want.hit_index) begin
            $display("%0t: hit_index mismatch, expected %0d, got %0d",
                     $time, want.hit_index, out_data.hit_index);
            failed = 1'b1;
          end
        end
        stall_left = ((got_count % 256) < 48) ? 0 : $urandom_range(0, 6);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    queue_directed();
    queue_random();
    total_items = queued_packets.size();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (sent_count < total_items || got_count < total_items) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!failed && pending_decisions.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hdl/fte_pkg.sv
hdl/fte_table.sv
hdl/flow_table_exact_match_top.sv
test/testbench.sv
